// ===== rtl/core/tmd_pkg.sv =====
package tmd_pkg;

  // Width of every breakpoint, sample and membership word on the ports
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_BOUND     = 2'd0,
    REG_PLATEAU_START = 2'd1,
    REG_PLATEAU_END   = 2'd2,
    REG_HIGH_BOUND    = 2'd3
  } tmd_reg_e;

  // How the degree of a word is formed
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_SLOPE = 2'd2
  } tmd_kind_e;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic      valid;
    tmd_kind_e kind;
  } tmd_ctl_t;

endpackage

// ===== rtl/core/tmd_classify.sv =====
module tmd_classify #(
  parameter int unsigned VW = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [tmd_pkg::DATA_W-1:0]      x_i,
  input  logic [tmd_pkg::DATA_W-1:0]      lo_i,
  input  logic [tmd_pkg::DATA_W-1:0]      ps_i,
  input  logic [tmd_pkg::DATA_W-1:0]      pe_i,
  input  logic [tmd_pkg::DATA_W-1:0]      hi_i,
  output tmd_pkg::tmd_ctl_t               ctl_o,
  output logic [VW:0]                     rem_o,
  output logic [VW-1:0]                   den_o
);
  import tmd_pkg::*;

  logic [VW-1:0] x, lo, ps, pe, hi;
  logic [VW-1:0] num_nxt, den_nxt;
  tmd_kind_e     kind_nxt;
  tmd_ctl_t      ctl_r;
  logic [VW:0]   rem_r;
  logic [VW-1:0] den_r;

  // Only the low VW bits of every value count
  assign x  = x_i[VW-1:0];
  assign lo = lo_i[VW-1:0];
  assign ps = ps_i[VW-1:0];
  assign pe = pe_i[VW-1:0];
  assign hi = hi_i[VW-1:0];

  // Region test: outside, falling edge, rising edge, plateau
  always_comb begin
    kind_nxt = KIND_FULL;
    num_nxt  = '0;
    den_nxt  = '0;
    if (x <= lo || x >= hi) begin
      kind_nxt = KIND_ZERO;
    end else if (x > pe) begin
      kind_nxt = KIND_SLOPE;
      num_nxt  = hi - x;
      den_nxt  = hi - pe;
    end else if (x < ps) begin
      kind_nxt = KIND_SLOPE;
      num_nxt  = x - lo;
      den_nxt  = ps - lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, kind: KIND_ZERO};
    end else if (en) begin
      ctl_r <= '{valid: in_valid, kind: kind_nxt};
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= {1'b0, num_nxt};
      den_r <= den_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;

endmodule

// ===== rtl/core/tmd_div_stage.sv =====
module tmd_div_stage #(
  parameter int unsigned VW = 16,
  parameter int unsigned FB = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tmd_pkg::tmd_ctl_t ctl_i,
  input  logic [VW:0]       rem_i,
  input  logic [VW-1:0]     den_i,
  input  logic [FB-1:0]     quo_i,
  output tmd_pkg::tmd_ctl_t ctl_o,
  output logic [VW:0]       rem_o,
  output logic [VW-1:0]     den_o,
  output logic [FB-1:0]     quo_o
);
  import tmd_pkg::*;

  logic [VW:0]   shifted;
  logic          take;
  logic [VW:0]   rem_nxt;
  tmd_ctl_t      ctl_r;
  logic [VW:0]   rem_r;
  logic [VW-1:0] den_r;
  logic [FB-1:0] quo_r;

  // One restoring step: remainder stays below the divisor
  assign shifted = {rem_i[VW-1:0], 1'b0};
  assign take    = shifted >= {1'b0, den_i};
  assign rem_nxt = take ? shifted - {1'b0, den_i} : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, kind: KIND_ZERO};
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= {quo_i[FB-2:0], take};
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule

// ===== rtl/core/trapezoidal_membership_degree.sv =====
// Trapezoidal fuzzy membership: each 16-bit sample word yields one
// membership word, unsigned with FRACTION_BITS fraction bits
// (1 << FRACTION_BITS is full degree, the port carries its low 16 bits),
// truncated toward zero. A new word is taken every cycle while in_stall
// is low. Each word passes one region-test stage, one restoring-divider
// stage per quotient bit and one output register. The pipeline advances
// as a whole; in_stall rises only while a finished result waits on
// out_stall. Breakpoints reset to 0; the user must write them through
// cfg_we/cfg_index/cfg_data only while no word is in flight (not enforced).
module trapezoidal_membership_degree #(
  parameter int unsigned VALUE_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmd_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tmd_pkg::DATA_W-1:0]        in_sample_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tmd_pkg::DATA_W-1:0]        out_membership
);
  import tmd_pkg::*;

  localparam int unsigned VW    = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned EXT_W = (FB + 1 > DATA_W) ? FB + 1 : DATA_W;
  localparam logic [FB:0] DEG_ONE = {1'b1, {FB{1'b0}}};

  logic [DATA_W-1:0] low_bound_r, plateau_start_r, plateau_end_r, high_bound_r;
  logic              advance;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_membership_r;
  logic [FB:0]       deg;
  logic [EXT_W-1:0]  deg_ext;

  tmd_ctl_t          ctl_s [0:FB];
  logic [VW:0]       rem_s [0:FB];
  logic [VW-1:0]     den_s [0:FB];
  logic [FB-1:0]     quo_s [0:FB];

  // Breakpoint registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r     <= '0;
      plateau_start_r <= '0;
      plateau_end_r   <= '0;
      high_bound_r    <= '0;
    end else if (cfg_we) begin
      case (tmd_reg_e'(cfg_index))
        REG_LOW_BOUND:     low_bound_r     <= cfg_data;
        REG_PLATEAU_START: plateau_start_r <= cfg_data;
        REG_PLATEAU_END:   plateau_end_r   <= cfg_data;
        REG_HIGH_BOUND:    high_bound_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output word is held
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  tmd_classify #(.VW(VW)) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_valid),
    .x_i      (in_sample_value),
    .lo_i     (low_bound_r),
    .ps_i     (plateau_start_r),
    .pe_i     (plateau_end_r),
    .hi_i     (high_bound_r),
    .ctl_o    (ctl_s[0]),
    .rem_o    (rem_s[0]),
    .den_o    (den_s[0])
  );

  assign quo_s[0] = '0;

  // One quotient bit per stage
  for (genvar k = 0; k < FB; k++) begin : g_div
    tmd_div_stage #(.VW(VW), .FB(FB)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .ctl_i (ctl_s[k]),
      .rem_i (rem_s[k]),
      .den_i (den_s[k]),
      .quo_i (quo_s[k]),
      .ctl_o (ctl_s[k+1]),
      .rem_o (rem_s[k+1]),
      .den_o (den_s[k+1]),
      .quo_o (quo_s[k+1])
    );
  end

  // Degree select and truncation to the port width
  always_comb begin
    case (ctl_s[FB].kind)
      KIND_FULL:  deg = DEG_ONE;
      KIND_SLOPE: deg = {1'b0, quo_s[FB]};
      default:    deg = '0;
    endcase
  end
  assign deg_ext = EXT_W'(deg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ctl_s[FB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_membership_r <= deg_ext[DATA_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_membership = out_membership_r;

  // A slope word always enters the divider with numerator below divisor
  a_slope_num_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[0].valid && ctl_s[0].kind == KIND_SLOPE |-> rem_s[0] < {1'b0, den_s[0]})
    else $error("slope numerator not below divisor");

  // Final remainder stays below divisor
  a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[FB].valid && ctl_s[FB].kind == KIND_SLOPE |-> rem_s[FB] < {1'b0, den_s[FB]})
    else $error("divider remainder out of range");

  // A held result word is not dropped
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_membership_r))
    else $error("stalled output word lost");

endmodule
